@@ rtl/ptst_pkg.sv @@
// ----------------------------------------------------------------------------
// ptst_pkg
// Shared types and constants for the pan/tilt slew-limited tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ptst_pkg;

  localparam int ACC_W   = 56;  // multiply-accumulate register
  localparam int MAC_A_W = 40;  // wide multiplier operand
  localparam int MAC_B_W = 18;  // narrow multiplier operand
  localparam int CROSS_W = 33;  // first cross product u x v
  localparam int CW      = 44;  // CORDIC datapath

  localparam int CORDIC_STEPS = 24;
  localparam int IDX_W        = 5;

  localparam logic signed [MAC_B_W-1:0] GAIN_Q16 = 18'sd107922;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [2:0] {
    CFG_PAN_MIN   = 3'd0,
    CFG_PAN_MAX   = 3'd1,
    CFG_PAN_STEP  = 3'd2,
    CFG_TILT_MIN  = 3'd3,
    CFG_TILT_MAX  = 3'd4,
    CFG_TILT_STEP = 3'd5,
    CFG_FIRE_PER  = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_PAN,
    ST_TILT,
    ST_FLIP,
    ST_SLEW
  } state_t;

  // one multiply-accumulate command
  typedef struct packed {
    logic en;    // update the accumulator
    logic load;  // start from the preset instead of the accumulator
    logic sub;   // subtract the product
    logic dbl;   // product times two
  } mac_op_t;

endpackage

`default_nettype wire

@@ rtl/pan_tilt_slew_limited_tracker.sv @@
// ----------------------------------------------------------------------------
// pan_tilt_slew_limited_tracker
// Two-axis turret pointing with per-axis slew limit and timed fire pulse.
// ----------------------------------------------------------------------------
// One tick is one input transfer and gives one output transfer. The block
// takes a tick through the shared multiply-accumulate unit (quaternion
// rotation of the aim vector and the gain correction of z, one product a
// cycle), two passes through the single iterative CORDIC (pan angle with
// horizontal length, then tilt; a pass whose operands are both zero skips
// the iterations), the flip decision and the slew, clamp and fire update,
// and is not ready meanwhile. A finished result sits in the output
// register, so the next tick can be taken while it waits; that tick's slew
// cycle then holds until the output register is free. Angles are 16-bit
// binary angle units (32768 = pi); vectors are Q1.14. Config writes are
// always taken and should only be made while no tick is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module pan_tilt_slew_limited_tracker import ptst_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  // input ticks
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // mount_qw, mount_qx, mount_qy, mount_qz, aim_x, aim_y, aim_z, elapsed_us, pad
  input  wire logic [135:0] s_axis_tdata,
  // fire_request
  input  wire logic         s_axis_tuser,
  // results
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // pan_angle, tilt_angle
  output logic [31:0]       m_axis_tdata,
  // fire_pulse
  output logic              m_axis_tuser,
  // configuration writes
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [23:0]  cfg_data
);

  // configuration
  logic signed [15:0] pan_min, pan_max, tilt_min, tilt_max;
  logic [14:0]        pan_step, tilt_step;
  logic [23:0]        fire_period_us;

  // tracker state
  logic signed [15:0] pan_now, tilt_now;
  logic [23:0]        since_fire_us;

  // captured tick
  logic signed [15:0] qw, qx, qy, qz, ax, ay, az;
  logic [19:0]        elapsed_us;
  logic               fire_request;

  state_t state, state_next;
  logic [3:0] step;

  // rotation intermediates
  logic signed [CROSS_W-1:0] cx, cy, cz;
  logic signed [MAC_A_W-1:0] rx, ry;
  logic signed [15:0]        pan_tgt, tilt_tgt;

  // shared units
  mac_op_t                   mac_op;
  logic signed [MAC_A_W-1:0] mac_a;
  logic signed [MAC_B_W-1:0] mac_b;
  logic signed [ACC_W-1:0]   mac_init;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_q14;
  logic signed [ACC_W-1:0]   acc_q16;

  logic                 cor_start;
  logic signed [CW-1:0] cor_num, cor_den;
  logic                 cor_done;
  logic signed [15:0]   cor_angle;
  logic signed [CW-1:0] cor_mag;

  // flip and slew
  logic signed [15:0] dp, dt, neg_tt;
  logic               do_flip;
  logic signed [15:0] pan_new, tilt_new;
  logic [24:0]        fire_sum;
  logic [23:0]        fire_sat;
  logic               pulse;
  logic               out_free;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  function automatic logic signed [MAC_A_W-1:0] ext16(input logic signed [15:0] v);
    return {{(MAC_A_W-16){v[15]}}, v};
  endfunction

  function automatic logic signed [MAC_A_W-1:0] extc(input logic signed [CROSS_W-1:0] v);
    return {{(MAC_A_W-CROSS_W){v[CROSS_W-1]}}, v};
  endfunction

  function automatic logic signed [MAC_B_W-1:0] extq(input logic signed [15:0] v);
    return {{(MAC_B_W-16){v[15]}}, v};
  endfunction

  function automatic logic signed [ACC_W-1:0] pre28(input logic signed [15:0] v);
    return {{(ACC_W-44){v[15]}}, v, 28'b0};
  endfunction

  // move toward target by at most step, then clamp: minimum first, maximum wins
  function automatic logic signed [15:0] slew_fn(
    input logic signed [15:0] cur,
    input logic signed [15:0] target,
    input logic signed [15:0] diff,
    input logic [14:0]        stp,
    input logic signed [15:0] lo,
    input logic signed [15:0] hi
  );
    logic signed [16:0] ad;
    logic signed [17:0] nx;
    ad = (diff < 0) ? -{diff[15], diff} : {diff[15], diff};
    if (ad <= $signed({2'b00, stp})) begin
      nx = {{2{target[15]}}, target};
    end else if (diff > 0) begin
      nx = $signed({{2{cur[15]}}, cur}) + $signed({3'b000, stp});
    end else begin
      nx = $signed({{2{cur[15]}}, cur}) - $signed({3'b000, stp});
    end
    if (nx < $signed({{2{lo[15]}}, lo})) begin
      nx = {{2{lo[15]}}, lo};
    end
    if (nx > $signed({{2{hi[15]}}, hi})) begin
      nx = {{2{hi[15]}}, hi};
    end
    return nx[15:0];
  endfunction

  ptst_mac u_mac (
    .clk  (clk),
    .op   (mac_op),
    .a    (mac_a),
    .b    (mac_b),
    .init (mac_init),
    .acc  (acc)
  );

  ptst_cordic u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cor_start),
    .num_in (cor_num),
    .den_in (cor_den),
    .done   (cor_done),
    .angle  (cor_angle),
    .mag    (cor_mag)
  );

  assign acc_q14 = acc >>> 14;
  assign acc_q16 = acc >>> 16;

  // Multiply-accumulate schedule. c = u x v first, then
  // r = v<<28 - 2w c + 2 u x c per component, then rz * gain.
  always_comb begin
    mac_op   = '0;
    mac_a    = '0;
    mac_b    = '0;
    mac_init = '0;
    if (state == ST_MAC) begin
      mac_op.en = 1'b1;
      unique case (step)
        4'd0:  begin mac_op.load = 1'b1; mac_a = ext16(az); mac_b = extq(qy); end
        4'd1:  begin mac_op.sub = 1'b1; mac_a = ext16(ay); mac_b = extq(qz); end
        4'd2:  begin mac_op.load = 1'b1; mac_a = ext16(ax); mac_b = extq(qz); end
        4'd3:  begin mac_op.sub = 1'b1; mac_a = ext16(az); mac_b = extq(qx); end
        4'd4:  begin mac_op.load = 1'b1; mac_a = ext16(ay); mac_b = extq(qx); end
        4'd5:  begin mac_op.sub = 1'b1; mac_a = ext16(ax); mac_b = extq(qy); end
        4'd6:  begin
          mac_op.load = 1'b1; mac_op.sub = 1'b1; mac_op.dbl = 1'b1;
          mac_init = pre28(ax); mac_a = extc(cx); mac_b = extq(qw);
        end
        4'd7:  begin mac_op.dbl = 1'b1; mac_a = extc(cz); mac_b = extq(qy); end
        4'd8:  begin mac_op.sub = 1'b1; mac_op.dbl = 1'b1; mac_a = extc(cy); mac_b = extq(qz); end
        4'd9:  begin
          mac_op.load = 1'b1; mac_op.sub = 1'b1; mac_op.dbl = 1'b1;
          mac_init = pre28(ay); mac_a = extc(cy); mac_b = extq(qw);
        end
        4'd10: begin mac_op.dbl = 1'b1; mac_a = extc(cx); mac_b = extq(qz); end
        4'd11: begin mac_op.sub = 1'b1; mac_op.dbl = 1'b1; mac_a = extc(cz); mac_b = extq(qx); end
        4'd12: begin
          mac_op.load = 1'b1; mac_op.sub = 1'b1; mac_op.dbl = 1'b1;
          mac_init = pre28(az); mac_a = extc(cz); mac_b = extq(qw);
        end
        4'd13: begin mac_op.dbl = 1'b1; mac_a = extc(cy); mac_b = extq(qx); end
        4'd14: begin mac_op.sub = 1'b1; mac_op.dbl = 1'b1; mac_a = extc(cx); mac_b = extq(qy); end
        4'd15: begin
          // rz straight off the accumulator, times the CORDIC gain
          mac_op.load = 1'b1; mac_a = acc_q14[MAC_A_W-1:0]; mac_b = GAIN_Q16;
        end
        default: mac_op = '0;
      endcase
    end
  end

  // CORDIC start: pan pass on (rx, ry), tilt pass on (h, rz * gain)
  always_comb begin
    cor_start = 1'b0;
    cor_num   = {{(CW-MAC_A_W){rx[MAC_A_W-1]}}, rx};
    cor_den   = {{(CW-MAC_A_W){ry[MAC_A_W-1]}}, ry};
    if (state == ST_MAC && step == 4'd15) begin
      cor_start = 1'b1;
    end else if (state == ST_PAN && cor_done) begin
      cor_start = 1'b1;
      cor_num   = cor_mag;
      cor_den   = {{(CW-40){acc_q16[39]}}, acc_q16[39:0]};
    end
  end

  // flip decision on the registered targets
  always_comb begin
    dp      = pan_tgt - pan_now;
    neg_tt  = -tilt_tgt;
    do_flip = ((dp > 16'sd16384) || (dp < -16'sd16384)) &&
              (tilt_min <= neg_tt) && (tilt_max >= neg_tt);
  end

  // slew, clamp and fire timer
  always_comb begin
    dt       = tilt_tgt - tilt_now;
    pan_new  = slew_fn(pan_now, pan_tgt, dp, pan_step, pan_min, pan_max);
    tilt_new = slew_fn(tilt_now, tilt_tgt, dt, tilt_step, tilt_min, tilt_max);
    fire_sum = {1'b0, since_fire_us} + {5'b0, elapsed_us};
    fire_sat = fire_sum[24] ? 24'hFF_FFFF : fire_sum[23:0];
    pulse    = fire_request && (fire_sat >= fire_period_us);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_axis_tvalid) state_next = ST_MAC;
      ST_MAC:  if (step == 4'd15) state_next = ST_PAN;
      ST_PAN:  if (cor_done) state_next = ST_TILT;
      ST_TILT: if (cor_done) state_next = ST_FLIP;
      ST_FLIP: state_next = ST_SLEW;
      ST_SLEW: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= (state == ST_MAC) ? step + 1'b1 : '0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pan_min        <= -16'sd32768;
      pan_max        <= 16'sd32767;
      pan_step       <= 15'd104;
      tilt_min       <= -16'sd16384;
      tilt_max       <= 16'sd16384;
      tilt_step      <= 15'd104;
      fire_period_us <= 24'd50000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PAN_MIN:   pan_min        <= cfg_data[15:0];
        CFG_PAN_MAX:   pan_max        <= cfg_data[15:0];
        CFG_PAN_STEP:  pan_step       <= cfg_data[14:0];
        CFG_TILT_MIN:  tilt_min       <= cfg_data[15:0];
        CFG_TILT_MAX:  tilt_max       <= cfg_data[15:0];
        CFG_TILT_STEP: tilt_step      <= cfg_data[14:0];
        CFG_FIRE_PER:  fire_period_us <= cfg_data;
        default: ;
      endcase
    end
  end

  // tick capture and intermediates
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_axis_tvalid) begin
      qw           <= s_axis_tdata[15:0];
      qx           <= s_axis_tdata[31:16];
      qy           <= s_axis_tdata[47:32];
      qz           <= s_axis_tdata[63:48];
      ax           <= s_axis_tdata[79:64];
      ay           <= s_axis_tdata[95:80];
      az           <= s_axis_tdata[111:96];
      elapsed_us   <= s_axis_tdata[131:112];
      fire_request <= s_axis_tuser;
    end
    if (state == ST_MAC) begin
      if (step == 4'd2)  cx <= acc[CROSS_W-1:0];
      if (step == 4'd4)  cy <= acc[CROSS_W-1:0];
      if (step == 4'd6)  cz <= acc[CROSS_W-1:0];
      if (step == 4'd9)  rx <= acc_q14[MAC_A_W-1:0];
      if (step == 4'd12) ry <= acc_q14[MAC_A_W-1:0];
    end
    if (state == ST_PAN && cor_done) begin
      pan_tgt <= -cor_angle;
    end
    if (state == ST_TILT && cor_done) begin
      tilt_tgt <= 16'sh8000 - cor_angle;
    end
    if (state == ST_FLIP && do_flip) begin
      pan_tgt  <= pan_tgt + 16'sh8000;
      tilt_tgt <= neg_tt;
    end
  end

  // tracker state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pan_now       <= '0;
      tilt_now      <= '0;
      since_fire_us <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (state == ST_SLEW && out_free) begin
        pan_now       <= pan_new;
        tilt_now      <= tilt_new;
        since_fire_us <= pulse ? 24'd0 : fire_sat;
        m_axis_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SLEW && out_free) begin
      m_axis_tdata <= {tilt_new, pan_new};
      m_axis_tuser <= pulse;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ptst_mac.sv @@
// ----------------------------------------------------------------------------
// ptst_mac
// Shared signed multiply-accumulate unit, one product per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ptst_mac import ptst_pkg::*; (
  input  wire logic                      clk,
  input  wire mac_op_t                   op,
  input  wire logic signed [MAC_A_W-1:0] a,
  input  wire logic signed [MAC_B_W-1:0] b,
  input  wire logic signed [ACC_W-1:0]   init,
  output logic signed [ACC_W-1:0]        acc
);

  logic signed [MAC_A_W+MAC_B_W-1:0] prod;
  logic signed [ACC_W-1:0]           term;
  logic signed [ACC_W-1:0]           base;
  logic signed [ACC_W-1:0]           acc_next;

  always_comb begin
    prod     = a * b;
    term     = op.dbl ? {prod[ACC_W-2:0], 1'b0} : prod[ACC_W-1:0];
    base     = op.load ? init : acc;
    acc_next = op.sub ? base - term : base + term;
  end

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc <= acc_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ptst_cordic.sv @@
// ----------------------------------------------------------------------------
// ptst_cordic
// Iterative vectoring CORDIC: angle and scaled magnitude, one step a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ptst_cordic import ptst_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [CW-1:0] num_in,
  input  wire logic signed [CW-1:0] den_in,
  output logic                      done,
  output logic signed [15:0]        angle,
  output logic signed [CW-1:0]      mag
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(CORDIC_STEPS - 1);

  logic signed [CW-1:0] num;
  logic signed [CW-1:0] den;
  logic [31:0]          z;
  logic [IDX_W-1:0]     iter;
  logic                 busy;
  logic                 in_zero;
  logic signed [CW-1:0] dn;
  logic signed [CW-1:0] dd;
  logic [31:0]          z_rnd;

  always_comb begin
    in_zero = (num_in == '0) && (den_in == '0);
    dn      = num >>> iter;
    dd      = den >>> iter;
    z_rnd   = z + 32'h0000_8000;
    angle   = z_rnd[31:16];
    mag     = den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= !in_zero;
        done <= in_zero;
        iter <= '0;
      end else if (busy) begin
        if (iter == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        iter <= iter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (in_zero) begin
        num <= '0;
        den <= '0;
        z   <= '0;
      end else if (den_in < 0) begin
        num <= -num_in;
        den <= -den_in;
        z   <= 32'h8000_0000;
      end else begin
        num <= num_in;
        den <= den_in;
        z   <= '0;
      end
    end else if (busy) begin
      if (num >= 0) begin
        den <= den + dn;
        num <= num - dd;
        z   <= z + ATAN_TAB[iter];
      end else begin
        den <= den - dn;
        num <= num + dd;
        z   <= z - ATAN_TAB[iter];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/ptst_checker.sv @@
// ----------------------------------------------------------------------------
// ptst_checker
// Port-level checks for the pan/tilt tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ptst_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  // nothing pending straight after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // one tick at a time: busy after a transfer in
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second tick taken while busy");

  // a new result only appears at the end of a tick's work
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without work");

endmodule

bind pan_tilt_slew_limited_tracker ptst_checker u_ptst_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
